FILE: design/stopwatch_seven_segment_scan_macros.svh
// assertion macros for the stopwatch display scanner
// no dependencies; included by the files that carry assertions
`ifndef STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH
`define STOPWATCH_SEVEN_SEGMENT_SCAN_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define STWS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stopwatch assertion failed");
// next-cycle implication
`define STWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stopwatch assertion failed");
`else
`define STWS_ASSERT_NOW(label, clk, rst, ante, cons)
`define STWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/stws_pkg.sv
// shared types, constants and the segment decode for the stopwatch scanner
// no dependencies
package stws_pkg;

  localparam int CountW    = 14;
  localparam int PrescaleW = 10;
  localparam int SampleW   = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] CFG_DELAY_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_COUNT_LIMIT   = 2'd2;

  localparam logic [SampleW-1:0]   SAMPLE_PERIOD_RST = 8'd6;
  localparam logic [PrescaleW-1:0] DELAY_LIMIT_RST   = 10'd10;
  localparam logic [CountW-1:0]    COUNT_LIMIT_RST   = 14'd9999;

  // reciprocals for division by 10, 100 and 1000, exact for 14-bit values
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam int          SHIFT_10   = 19;
  localparam logic [15:0] RECIP_100  = 16'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [15:0] RECIP_1000 = 16'd8389;
  localparam int          SHIFT_1000 = 23;

  typedef struct packed {
    logic [SampleW-1:0]   sample_period;
    logic [PrescaleW-1:0] delay_limit;
    logic [CountW-1:0]    count_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        digit_select;
    logic [6:0]        segments;
    logic [CountW-1:0] count_value;
    logic              running;
  } result_t;

  // active-high a..g, bit0 is segment a; anything above nine is blank
  function automatic logic [6:0] seg_pattern(input logic [4:0] digit);
    logic [6:0] pat;
    case (digit)
      5'd0: pat = 7'h3F;
      5'd1: pat = 7'h06;
      5'd2: pat = 7'h5B;
      5'd3: pat = 7'h4F;
      5'd4: pat = 7'h66;
      5'd5: pat = 7'h6D;
      5'd6: pat = 7'h7D;
      5'd7: pat = 7'h07;
      5'd8: pat = 7'h7F;
      5'd9: pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

FILE: design/stopwatch_seven_segment_scan.sv
// stopwatch with a scanned four-digit seven-segment display
// a taken request sits in the input register, then its result in the result register
// throughput: one request per cycle while out_stall is low; input and result register keep it flowing
// reset: synchronous; clears run flags, counters and scan position, config back to defaults
// depends on stws_pkg and stws_core
module stopwatch_seven_segment_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        start_stop_level,
  input  logic                        reset_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  digit_select,
  output logic [6:0]                  segments,
  output logic [stws_pkg::CountW-1:0] count_value,
  output logic                        running,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [stws_pkg::CountW-1:0] cfg_data
);
  import stws_pkg::*;

  cfg_t       cfg;
  logic       in_full;
  logic [1:0] in_levels;
  logic       advance;
  result_t    core_result;
  result_t    out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_period <= SAMPLE_PERIOD_RST;
      cfg.delay_limit   <= DELAY_LIMIT_RST;
      cfg.count_limit   <= COUNT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data[SampleW-1:0];
        CFG_DELAY_LIMIT:   cfg.delay_limit   <= cfg_data[PrescaleW-1:0];
        CFG_COUNT_LIMIT:   cfg.count_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the request in the input register moves on once the result slot frees
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && !in_stall) || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_levels <= {reset_level, start_stop_level};
    end
  end

  stws_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .levels (in_levels),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign digit_select = out_result.digit_select;
  assign segments     = out_result.segments;
  assign count_value  = out_result.count_value;
  assign running      = out_result.running;

endmodule

FILE: design/stws_digit.sv
// picks one decimal digit of the shown count and decodes it to segments
// depends on stws_pkg
module stws_digit (
  input  logic [stws_pkg::CountW-1:0] value,
  input  logic [1:0]                  pos,
  output logic [6:0]                  segments
);
  import stws_pkg::*;

  logic [29:0]       prod_10;
  logic [29:0]       prod_100;
  logic [29:0]       prod_1000;
  logic [CountW-1:0] q_10;
  logic [CountW-1:0] q_100;
  logic [CountW-1:0] q_1000;
  logic [CountW-1:0] q_lo;
  logic [CountW-1:0] q_hi;
  logic [CountW-1:0] diff;

  assign prod_10   = 30'(value) * 30'(RECIP_10);
  assign prod_100  = 30'(value) * 30'(RECIP_100);
  assign prod_1000 = 30'(value) * 30'(RECIP_1000);

  assign q_10   = CountW'(prod_10   >> SHIFT_10);
  assign q_100  = CountW'(prod_100  >> SHIFT_100);
  assign q_1000 = CountW'(prod_1000 >> SHIFT_1000);

  // digit = floor(v / 10^k) - 10 * floor(v / 10^(k+1))
  always_comb begin
    case (pos)
      2'd0: begin
        q_lo = value;
        q_hi = q_10;
      end
      2'd1: begin
        q_lo = q_10;
        q_hi = q_100;
      end
      2'd2: begin
        q_lo = q_100;
        q_hi = q_1000;
      end
      default: begin
        q_lo = q_1000;
        q_hi = '0;
      end
    endcase
  end

  assign diff     = q_lo - ((q_hi << 3) + (q_hi << 1));
  assign segments = seg_pattern(diff[4:0]);

endmodule

FILE: design/stws_core.sv
// stopwatch state: button sampling, run control, prescaler, count and scan
// depends on stws_pkg, stws_digit and the assertion macro header
`include "stopwatch_seven_segment_scan_macros.svh"

module stws_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [1:0]        levels,
  input  stws_pkg::cfg_t    cfg,
  output stws_pkg::result_t result
);
  import stws_pkg::*;

  logic                 started;
  logic                 run_flag;
  logic                 edge_enable;
  logic [SampleW-1:0]   sample_count;
  logic [1:0]           previous_levels;
  logic [1:0]           rising_edges;
  logic [CountW-1:0]    elapsed_count;
  logic [PrescaleW-1:0] prescale_count;
  logic [1:0]           scan_position;

  logic                 started_next;
  logic                 run_flag_next;
  logic                 edge_enable_next;
  logic [SampleW-1:0]   sample_count_next;
  logic [1:0]           previous_levels_next;
  logic [1:0]           rising_edges_next;
  logic [CountW-1:0]    elapsed_count_next;
  logic [PrescaleW-1:0] prescale_count_next;
  logic [CountW-1:0]    shown;
  logic                 run_btn;
  logic                 started_btn;
  logic [6:0]           segments;

  always_comb begin
    // button edges latched at the last sample act on this tick only
    run_btn     = run_flag;
    started_btn = started;
    if (rising_edges[0] && edge_enable) begin
      if (run_flag) begin
        run_btn = 1'b0;
      end else begin
        run_btn     = 1'b1;
        started_btn = 1'b1;
      end
    end
    if (rising_edges[1] && edge_enable) begin
      run_btn     = 1'b0;
      started_btn = 1'b0;
    end

    started_next        = started_btn;
    run_flag_next       = run_btn;
    elapsed_count_next  = elapsed_count;
    prescale_count_next = prescale_count;
    shown               = '0;
    if (started_btn) begin
      shown = elapsed_count;
      if (run_btn) begin
        if (elapsed_count >= cfg.count_limit) begin
          run_flag_next = 1'b0;
        end else if (prescale_count >= cfg.delay_limit) begin
          elapsed_count_next  = elapsed_count + 1'b1;
          prescale_count_next = '0;
        end else begin
          prescale_count_next = prescale_count + 1'b1;
        end
      end
    end else begin
      elapsed_count_next  = '0;
      prescale_count_next = '0;
    end

    if (sample_count >= cfg.sample_period) begin
      rising_edges_next    = levels & ~previous_levels;
      previous_levels_next = levels;
      sample_count_next    = '0;
      edge_enable_next     = 1'b1;
    end else begin
      rising_edges_next    = rising_edges;
      previous_levels_next = previous_levels;
      sample_count_next    = sample_count + 1'b1;
      edge_enable_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      run_flag        <= 1'b0;
      edge_enable     <= 1'b0;
      sample_count    <= '0;
      previous_levels <= '0;
      rising_edges    <= '0;
      elapsed_count   <= '0;
      prescale_count  <= '0;
      scan_position   <= '0;
    end else if (step) begin
      started         <= started_next;
      run_flag        <= run_flag_next;
      edge_enable     <= edge_enable_next;
      sample_count    <= sample_count_next;
      previous_levels <= previous_levels_next;
      rising_edges    <= rising_edges_next;
      elapsed_count   <= elapsed_count_next;
      prescale_count  <= prescale_count_next;
      scan_position   <= scan_position + 1'b1;
    end
  end

  stws_digit u_digit (
    .value    (shown),
    .pos      (scan_position),
    .segments (segments)
  );

  assign result.digit_select = scan_position;
  assign result.segments     = segments;
  assign result.count_value  = shown;
  assign result.running      = run_flag_next;

  `STWS_ASSERT_NOW(a_idle_cleared, clk, rst, !started, (elapsed_count == '0) && (prescale_count == '0))
  `STWS_ASSERT_NOW(a_run_needs_start, clk, rst, run_flag, started)
  `STWS_ASSERT_NOW(a_edge_after_sample, clk, rst, edge_enable, sample_count == '0)
  `STWS_ASSERT_NEXT(a_scan_advances, clk, rst, step, scan_position == 2'($past(scan_position) + 2'd1))

endmodule
